// ===== hdl/csvtok_pkg.sv =====
// ----------------------------------------------------------------------------
// csvtok_pkg: shared types and character codes
// Character constants and the result word layout used by the CSV tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       row_end;
  } csvtok_res_t;

endpackage

// ===== hdl/csvtok_core.sv =====
// ----------------------------------------------------------------------------
// csvtok_core: tokenizer state and per-byte decode
// Holds the parser flags and the held value byte; computes at most one result per word.
// ----------------------------------------------------------------------------
module csvtok_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    stream_end,
  output logic                    res_valid,
  output csvtok_pkg::csvtok_res_t res
);
  import csvtok_pkg::*;

  logic [7:0] held_byte_r,    held_byte_nxt;
  logic       held_valid_r,   held_valid_nxt;
  logic       field_empty_r,  field_empty_nxt;
  logic       quoted_mode_r,  quoted_mode_nxt;
  logic       inside_value_r, inside_value_nxt;
  logic       first_row_r,    first_row_nxt;
  logic       row_open_r,     row_open_nxt;

  logic       qmode;
  logic       escaped;
  logic [7:0] held_out;

  assign held_out = held_valid_r ? held_byte_r : 8'h00;
  assign qmode    = quoted_mode_r | (field_empty_r & first_row_r);
  assign escaped  = ~field_empty_r & held_valid_r & (held_byte_r == CH_BACKSLASH);

  always_comb begin
    held_byte_nxt    = held_byte_r;
    held_valid_nxt   = held_valid_r;
    field_empty_nxt  = field_empty_r;
    quoted_mode_nxt  = quoted_mode_r;
    inside_value_nxt = inside_value_r;
    first_row_nxt    = first_row_r;
    row_open_nxt     = row_open_r;
    res_valid        = 1'b0;
    res              = '0;
    if (accept) begin
      if (stream_end) begin
        // close an open row, then return to reset state
        if (row_open_r) begin
          res_valid = 1'b1;
          res       = '{out_byte: held_out, byte_valid: held_valid_r,
                        field_end: 1'b1, row_end: 1'b1};
        end
        held_byte_nxt    = 8'h00;
        held_valid_nxt   = 1'b0;
        field_empty_nxt  = 1'b1;
        quoted_mode_nxt  = 1'b0;
        inside_value_nxt = 1'b0;
        first_row_nxt    = 1'b1;
        row_open_nxt     = 1'b0;
      end else if (data_byte == CH_NEWLINE) begin
        // close an open row; drop blank lines
        if (row_open_r) begin
          res_valid       = 1'b1;
          res             = '{out_byte: held_out, byte_valid: held_valid_r,
                              field_end: 1'b1, row_end: 1'b1};
          held_byte_nxt   = 8'h00;
          held_valid_nxt  = 1'b0;
          field_empty_nxt = 1'b1;
          row_open_nxt    = 1'b0;
          first_row_nxt   = 1'b0;
        end
      end else begin
        row_open_nxt = 1'b1;
        if (data_byte == CH_QUOTE) begin
          quoted_mode_nxt = qmode;
          if (qmode) begin
            if (!escaped) begin
              inside_value_nxt = ~inside_value_r;
            end else if (inside_value_r) begin
              held_byte_nxt = CH_QUOTE;
            end
          end
        end else if (data_byte == CH_COMMA && !inside_value_r) begin
          res_valid       = 1'b1;
          res             = '{out_byte: held_out, byte_valid: held_valid_r,
                              field_end: 1'b1, row_end: 1'b0};
          held_byte_nxt   = 8'h00;
          held_valid_nxt  = 1'b0;
          field_empty_nxt = 1'b1;
        end else if (inside_value_r || !quoted_mode_r) begin
          // release the previous byte, hold the new one
          if (held_valid_r) begin
            res_valid = 1'b1;
            res       = '{out_byte: held_byte_r, byte_valid: 1'b1,
                          field_end: 1'b0, row_end: 1'b0};
          end
          held_byte_nxt   = data_byte;
          held_valid_nxt  = 1'b1;
          field_empty_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r    <= 8'h00;
      held_valid_r   <= 1'b0;
      field_empty_r  <= 1'b1;
      quoted_mode_r  <= 1'b0;
      inside_value_r <= 1'b0;
      first_row_r    <= 1'b1;
      row_open_r     <= 1'b0;
    end else begin
      held_byte_r    <= held_byte_nxt;
      held_valid_r   <= held_valid_nxt;
      field_empty_r  <= field_empty_nxt;
      quoted_mode_r  <= quoted_mode_nxt;
      inside_value_r <= inside_value_nxt;
      first_row_r    <= first_row_nxt;
      row_open_r     <= row_open_nxt;
    end
  end

endmodule

// ===== hdl/csvtok_obuf.sv =====
// ----------------------------------------------------------------------------
// csvtok_obuf: two-entry result buffer
// Output register plus skid slot so one more result can be taken while the output stalls.
// ----------------------------------------------------------------------------
module csvtok_obuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  csvtok_pkg::csvtok_res_t push_data,
  output logic                    space,
  output logic                    head_valid,
  output csvtok_pkg::csvtok_res_t head_data,
  input  logic                    pop_ready
);
  import csvtok_pkg::*;

  csvtok_res_t head_r, head_nxt;
  csvtok_res_t tail_r, tail_nxt;
  logic        head_vld_r, head_vld_nxt;
  logic        tail_vld_r, tail_vld_nxt;
  logic        pop;

  assign pop        = head_vld_r & pop_ready;
  assign space      = ~tail_vld_r;
  assign head_valid = head_vld_r;
  assign head_data  = head_r;

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    head_vld_nxt = head_vld_r;
    tail_vld_nxt = tail_vld_r;
    if (tail_vld_r) begin
      if (pop) begin
        head_nxt     = tail_r;
        tail_vld_nxt = 1'b0;
      end
    end else if (!head_vld_r || pop) begin
      head_nxt     = push_data;
      head_vld_nxt = push;
    end else if (push) begin
      tail_nxt     = push_data;
      tail_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      tail_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      tail_vld_r <= tail_vld_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== hdl/csv_field_tokenizer.sv =====
// Result path: each result word is registered in the buffer's head register, or
//   first in the skid slot while the head is stalled, before it drives the outputs.
// Throughput: one input word per cycle; in_ready drops only while both result
//   slots are full.
// Reset: synchronous rst_n clears all parser flags and empties the result buffer.
// ----------------------------------------------------------------------------
// csv_field_tokenizer: CSV byte stream to value bytes with field/row marks
// Parser flags in csvtok_core, results buffered in a two-entry csvtok_obuf.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_field_end,
  output logic       out_row_end
);
  import csvtok_pkg::*;

  logic        accept;    // input word taken this cycle
  logic        res_valid; // that word produces a result word
  csvtok_res_t res;
  csvtok_res_t head;
  logic        space;

  // Accept whenever the skid slot is free; a word that yields no result
  // never needs buffer room, but gating on one flag keeps ready simple.
  assign in_ready = space;
  assign accept   = in_valid & in_ready;

  // Decode the word and advance the parser flags in the same cycle.
  csvtok_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Hold results until the consumer takes them.
  csvtok_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .space      (space),
    .head_valid (out_valid),
    .head_data  (head),
    .pop_ready  (out_ready)
  );

  assign out_byte       = head.out_byte;
  assign out_byte_valid = head.byte_valid;
  assign out_field_end  = head.field_end;
  assign out_row_end    = head.row_end;

endmodule

// ===== hdl/csvtok_checker.sv =====
// ----------------------------------------------------------------------------
// csvtok_checker: port-level checks for the CSV tokenizer
// Watches the top-level ports over time; attached to the top by bind.
// ----------------------------------------------------------------------------
module csvtok_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_data_byte,
  input logic       in_stream_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_field_end,
  input logic       out_row_end
);

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) &&
      $stable(in_stream_end))
    else $error("offered input word changed before acceptance");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_field_end) && $stable(out_row_end))
    else $error("stalled result word changed");

  // row end only comes with a field end
  a_row_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_field_end)
    else $error("row_end without field_end");

  // empty field carries a zero byte; a word without a byte always ends a field
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'h00 && out_field_end)
    else $error("empty result word malformed");

  // after reset the buffer is empty and input is open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("buffer not cleared by reset");

endmodule

bind csv_field_tokenizer csvtok_checker u_csvtok_checker (.*);
